### rtl/mi4_pkg.sv
// Shared types and constants of the 4x4 matrix inverse core.
// Used by mi4_ctrl, mi4_dp and the top level; no dependencies.
package mi4_pkg;

  localparam int ELEM_W = 32;   // element and result width
  localparam int LIMB_W = 32;   // multiplier operand width
  localparam int P_W    = 128;  // product register, four limbs
  localparam int A_W    = 97;   // signed 3x3 minor
  localparam int D_W    = 131;  // signed determinant
  localparam int MAG_W  = 130;  // determinant magnitude
  localparam int THR_W  = 31;
  localparam int IDX_W  = 4;

  localparam logic [THR_W-1:0] THR_RESET = 31'd66;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE,
    OP_CLR_DET,
    OP_CLR_ACC,
    OP_LOAD_P,
    OP_LOAD_P_ACC,
    OP_MUL_CLR,
    OP_MUL_LIMB,
    OP_MUL_DONE,
    OP_ACC,
    OP_DET_ACC,
    OP_MAG,
    OP_SING,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [IDX_W-1:0]   addr;
    logic [1:0]         limb;
    logic               neg;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } dp_cmd_t;

  typedef struct packed {
    logic singular;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR_DET,
    ST_MCLR,
    ST_TLOAD,
    ST_MCLRM,
    ST_MLIMB,
    ST_MDRAIN,
    ST_MDONE,
    ST_TACC,
    ST_DLOADP,
    ST_DACC,
    ST_MAG,
    ST_SING,
    ST_OUT,
    ST_DIVI,
    ST_DIVS,
    ST_EMIT
  } ctl_state_t;

endpackage

### rtl/mi4_ctrl.sv
// Sequencer of the 4x4 matrix inverse core: loads, minors, determinant,
// division and emission. Depends on mi4_pkg.
module mi4_ctrl import mi4_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;     // load count
  logic [1:0] c_r, c_nxt;         // determinant column
  logic [2:0] t_r, t_nxt;         // product term of a minor
  logic [1:0] f_r, f_nxt;         // factor within a term
  logic [1:0] limb_r, limb_nxt;
  logic       dmul_r, dmul_nxt;   // multiplying minor by first-row element
  logic       det_r, det_nxt;     // minors feed the determinant
  logic [3:0] k_r, k_nxt;         // output index
  logic [4:0] bit_r, bit_nxt;     // quotient bit

  logic [1:0] sr, sc, kk, row, col;
  logic       flip;
  logic [5:0] cols;

  // column picked by factor f of term t (three plus, three minus terms)
  always_comb begin
    case (t_r)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd0, 2'd2, 2'd1};
      3'd2:    cols = {2'd1, 2'd0, 2'd2};
      3'd3:    cols = {2'd0, 2'd1, 2'd2};
      3'd4:    cols = {2'd2, 2'd0, 2'd1};
      3'd5:    cols = {2'd1, 2'd2, 2'd0};
      default: cols = {2'd2, 2'd1, 2'd0};
    endcase
  end

  // element address inside the minor that skips row sr and column sc
  always_comb begin
    sr   = det_r ? 2'd0 : k_r[1:0];
    sc   = det_r ? c_r  : k_r[3:2];
    flip = det_r ? 1'b0 : (k_r[0] ^ k_r[2]);
    kk   = cols[{f_r, 1'b0} +: 2];
    row  = 2'(f_r + {1'b0, (f_r >= sr)});
    col  = 2'(kk + {1'b0, (kk >= sc)});
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      c_r     <= '0;
      t_r     <= '0;
      f_r     <= '0;
      limb_r  <= '0;
      dmul_r  <= 1'b0;
      det_r   <= 1'b0;
      k_r     <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      c_r     <= c_nxt;
      t_r     <= t_nxt;
      f_r     <= f_nxt;
      limb_r  <= limb_nxt;
      dmul_r  <= dmul_nxt;
      det_r   <= det_nxt;
      k_r     <= k_nxt;
      bit_r   <= bit_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    c_nxt     = c_r;
    t_nxt     = t_r;
    f_nxt     = f_r;
    limb_nxt  = limb_r;
    dmul_nxt  = dmul_r;
    det_nxt   = det_r;
    k_nxt     = k_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.op    = OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op   = OP_WRITE;
          cmd.addr = cnt_r;
          cnt_nxt  = 4'(cnt_r + 4'd1);
          if (cnt_r == 4'hF) state_nxt = ST_CLR_DET;
        end
      end
      ST_CLR_DET: begin
        cmd.op    = OP_CLR_DET;
        det_nxt   = 1'b1;
        c_nxt     = '0;
        state_nxt = ST_MCLR;
      end
      ST_MCLR: begin
        cmd.op    = OP_CLR_ACC;
        t_nxt     = '0;
        f_nxt     = '0;
        state_nxt = ST_TLOAD;
      end
      ST_TLOAD: begin
        cmd.op    = OP_LOAD_P;
        cmd.addr  = {row, col};
        f_nxt     = 2'd1;
        state_nxt = ST_MCLRM;
      end
      ST_MCLRM: begin
        cmd.op    = OP_MUL_CLR;
        cmd.addr  = dmul_r ? {2'b00, c_r} : {row, col};
        limb_nxt  = '0;
        state_nxt = ST_MLIMB;
      end
      ST_MLIMB: begin
        cmd.op   = OP_MUL_LIMB;
        cmd.limb = limb_r;
        // product width grows one limb per factor
        if (dmul_r ? (limb_r == 2'd2) : (limb_r == 2'(f_r - 2'd1))) begin
          state_nxt = ST_MDRAIN;
        end else begin
          limb_nxt = 2'(limb_r + 2'd1);
        end
      end
      ST_MDRAIN: begin
        state_nxt = ST_MDONE;
      end
      ST_MDONE: begin
        cmd.op = OP_MUL_DONE;
        if (dmul_r) begin
          state_nxt = ST_DACC;
        end else if (f_r == 2'd2) begin
          state_nxt = ST_TACC;
        end else begin
          f_nxt     = 2'(f_r + 2'd1);
          state_nxt = ST_MCLRM;
        end
      end
      ST_TACC: begin
        cmd.op  = OP_ACC;
        cmd.neg = (t_r >= 3'd3) ^ flip;
        f_nxt   = '0;
        if (t_r == 3'd5) begin
          state_nxt = det_r ? ST_DLOADP : ST_DIVI;
        end else begin
          t_nxt     = 3'(t_r + 3'd1);
          state_nxt = ST_TLOAD;
        end
      end
      ST_DLOADP: begin
        cmd.op    = OP_LOAD_P_ACC;
        dmul_nxt  = 1'b1;
        state_nxt = ST_MCLRM;
      end
      ST_DACC: begin
        cmd.op   = OP_DET_ACC;
        cmd.neg  = c_r[0];
        dmul_nxt = 1'b0;
        if (c_r == 2'd3) begin
          state_nxt = ST_MAG;
        end else begin
          c_nxt     = 2'(c_r + 2'd1);
          state_nxt = ST_MCLR;
        end
      end
      ST_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = ST_SING;
      end
      ST_SING: begin
        cmd.op    = OP_SING;
        det_nxt   = 1'b0;
        k_nxt     = '0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        state_nxt = sts.singular ? ST_EMIT : ST_MCLR;
      end
      ST_DIVI: begin
        cmd.op    = OP_DIV_INIT;
        bit_nxt   = '0;
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.op = OP_DIV_STEP;
        if (bit_r == 5'd31) state_nxt = ST_EMIT;
        else bit_nxt = 5'(bit_r + 5'd1);
      end
      ST_EMIT: begin
        cmd.op   = OP_EMIT;
        cmd.idx  = k_r;
        cmd.last = (k_r == 4'hF);
        if (k_r == 4'hF) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = 4'(k_r + 4'd1);
          state_nxt = ST_OUT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/mi4_dp.sv
// Datapath of the 4x4 matrix inverse core: element store, limb multiplier,
// minor and determinant accumulators, restoring divider. Depends on mi4_pkg.
module mi4_dp import mi4_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                     cfg_wr_en,
  input  logic [THR_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  output logic signed [ELEM_W-1:0] out_inverse_value,
  output logic [IDX_W-1:0]         out_element_index,
  output logic                     out_is_singular,
  output logic                     out_was_saturated,
  output logic                     out_is_last
);

  localparam int CW = MAG_W + ELEM_W;  // divider compare width

  logic [ELEM_W-1:0] store_r [16];
  logic [ELEM_W-1:0] rd, rd_mag;
  logic [P_W-1:0]    p_r, pn_r;
  logic              s_r;
  logic [LIMB_W-1:0] y_r;
  logic [2*LIMB_W-1:0] m_r;
  logic [1:0]        ml_r;
  logic              mv_r;
  logic [A_W-1:0]    acc_r, a_mag, p_a;
  logic [D_W-1:0]    det_r, p_d;
  logic [MAG_W-1:0]  mag_r;
  logic              sing_r;
  logic [THR_W-1:0]  thr_r;
  logic [CW-1:0]     rem_r, sh_r, sh_half, num;
  logic              ge;
  logic [ELEM_W-1:0] q_r;
  logic              ovf_r, cneg_r;
  logic [ELEM_W-1:0] val;
  logic              sat;

  // store read and operand magnitude
  assign rd     = store_r[cmd.addr];
  assign rd_mag = rd[ELEM_W-1] ? ELEM_W'(0 - rd) : rd;

  assign a_mag   = acc_r[A_W-1] ? A_W'(0 - acc_r) : acc_r;
  assign p_a     = A_W'(p_r);
  assign p_d     = D_W'(p_r);
  assign num     = CW'(a_mag) << (2 * FRAC_BITS);
  assign sh_half = sh_r >> 1;
  assign ge      = (rem_r >= sh_half);

  assign sts.singular = sing_r;

  // result value with saturation
  always_comb begin
    val = '0;
    sat = 1'b0;
    if (!sing_r) begin
      if (!cneg_r) begin
        if (ovf_r || q_r[ELEM_W-1]) begin
          val = {1'b0, {(ELEM_W-1){1'b1}}};
          sat = 1'b1;
        end else begin
          val = q_r;
        end
      end else begin
        if (ovf_r || (q_r > {1'b1, {(ELEM_W-1){1'b0}}})) begin
          val = {1'b1, {(ELEM_W-1){1'b0}}};
          sat = 1'b1;
        end else begin
          val = ELEM_W'(0 - q_r);
        end
      end
    end
  end

  // element store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) store_r[cmd.addr] <= in_element_value;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r      <= 1'b0;
      out_valid <= 1'b0;
      thr_r     <= THR_RESET;
    end else begin
      mv_r      <= (cmd.op == OP_MUL_LIMB);
      out_valid <= (cmd.op == OP_EMIT);
      if (cfg_wr_en) thr_r <= cfg_wr_data;
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (mv_r) pn_r <= P_W'(pn_r + (P_W'(m_r) << {ml_r, 5'b0}));
    case (cmd.op)
      OP_CLR_DET: det_r <= '0;
      OP_CLR_ACC: acc_r <= '0;
      OP_LOAD_P: begin
        p_r <= P_W'(rd_mag);
        s_r <= rd[ELEM_W-1];
      end
      OP_LOAD_P_ACC: begin
        p_r <= P_W'(a_mag);
        s_r <= acc_r[A_W-1];
      end
      OP_MUL_CLR: begin
        y_r  <= rd_mag;
        s_r  <= s_r ^ rd[ELEM_W-1];
        pn_r <= '0;
      end
      OP_MUL_LIMB: begin
        m_r  <= p_r[{cmd.limb, 5'b0} +: LIMB_W] * y_r;
        ml_r <= cmd.limb;
      end
      OP_MUL_DONE: p_r <= pn_r;
      OP_ACC: acc_r <= A_W'(acc_r + ((s_r ^ cmd.neg) ? A_W'(0 - p_a) : p_a));
      OP_DET_ACC: det_r <= D_W'(det_r + ((s_r ^ cmd.neg) ? D_W'(0 - p_d) : p_d));
      OP_MAG: mag_r <= det_r[D_W-1] ? MAG_W'(0 - det_r) : MAG_W'(det_r);
      OP_SING: sing_r <= ((MAG_W'(thr_r) << (3 * FRAC_BITS)) >= mag_r);
      OP_DIV_INIT: begin
        cneg_r <= acc_r[A_W-1] ^ det_r[D_W-1];
        rem_r  <= num;
        sh_r   <= CW'(mag_r) << ELEM_W;
        ovf_r  <= (num >= (CW'(mag_r) << ELEM_W));
        q_r    <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? CW'(rem_r - sh_half) : rem_r;
        sh_r  <= sh_half;
        q_r   <= {q_r[ELEM_W-2:0], ge};
      end
      OP_EMIT: begin
        out_inverse_value <= val;
        out_element_index <= cmd.idx;
        out_is_singular   <= sing_r;
        out_was_saturated <= sat;
        out_is_last       <= cmd.last;
      end
      default: ;
    endcase
  end

endmodule

### rtl/matrix_inverse_4x4_core.sv
// 4x4 Q16.16 matrix inverse by adjugate. One element request per cycle while
// idle; after the 16th, the determinant is formed, then the 16 results follow
// in index order, with no division when the matrix is singular.
// Rate set by the single 32x32 limb multiplier and the bit-serial divider.
// Synchronous active-low reset clears control and sets the threshold to 66.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module matrix_inverse_4x4_core import mi4_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                     cfg_wr_en,
  input  logic [THR_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  output logic signed [ELEM_W-1:0] out_inverse_value,
  output logic [IDX_W-1:0]         out_element_index,
  output logic                     out_is_singular,
  output logic                     out_was_saturated,
  output logic                     out_is_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mi4_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mi4_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_element_value  (in_element_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_inverse_value (out_inverse_value),
    .out_element_index (out_element_index),
    .out_is_singular   (out_is_singular),
    .out_was_saturated (out_was_saturated),
    .out_is_last       (out_is_last)
  );

endmodule

### rtl/mi4_checker.sv
// Port-level checks for matrix_inverse_4x4_core, bound to the top level.
// No package dependencies.
module mi4_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_inverse_value,
  input logic [3:0]  out_element_index,
  input logic        out_is_singular,
  input logic        out_was_saturated,
  input logic        out_is_last
);

  // only the final result may appear after the core went idle
  a_busy_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> busy)
    else $error("non-final result while idle");

  // singular runs give zero values without saturation
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_singular |-> out_inverse_value == 32'd0 && !out_was_saturated)
    else $error("singular result not zero");

  // last flag goes with the final index
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_last == (out_element_index == 4'hF)))
    else $error("last flag and index disagree");

  // results never come in adjacent cycles
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

endmodule

bind matrix_inverse_4x4_core mi4_checker u_mi4_checker (.*);

### test/tb_matrix_inverse_4x4_core.sv
// Self-checking testbench for matrix_inverse_4x4_core: random matrices and
// thresholds, results checked against an exact adjugate predictor.
// Depends on mi4_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_matrix_inverse_4x4_core import mi4_pkg::*; ();

  localparam int FRAC       = 16;
  localparam int SETTLE     = 60;      // idle cycles before a threshold write
  localparam int LIMIT      = 300000;  // run timeout in cycles
  localparam int RAND_MATS  = 5;

  typedef logic signed [191:0] wide_t;

  // matrix flavors used by the random part
  typedef enum int {
    MAT_FULL, MAT_SMALL, MAT_DUP_ROW, MAT_TINY_DIAG, MAT_ZERO, MAT_FLAVORS
  } mat_kind_t;

  typedef struct {
    logic                     is_cfg;
    logic [ELEM_W-1:0]        value;
  } request_t;

  typedef struct {
    logic signed [ELEM_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     singular;
    logic                     saturated;
    logic                     last;
  } inv_entry_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     cfg_wr_en;
  logic [THR_W-1:0]         cfg_wr_data;
  logic                     out_valid;
  logic signed [ELEM_W-1:0] out_inverse_value;
  logic [IDX_W-1:0]         out_element_index;
  logic                     out_is_singular;
  logic                     out_was_saturated;
  logic                     out_is_last;

  request_t   pending_req[$];
  inv_entry_t expected_inv[$];

  // predictor state
  logic signed [ELEM_W-1:0] mat_copy[16];
  int unsigned              load_cnt;
  logic [THR_W-1:0]         thr_copy;

  int  error_count;
  int  cycle_count;
  int  gap_left;
  int  settle_cnt;
  logic nxt_start;
  logic nxt_wr;

  matrix_inverse_4x4_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_element_value  (in_element_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_inverse_value (out_inverse_value),
    .out_element_index (out_element_index),
    .out_is_singular   (out_is_singular),
    .out_was_saturated (out_was_saturated),
    .out_is_last       (out_is_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // 3x3 minor without row sr and column sc, exact
  function automatic wide_t minor3(int sr, int sc);
    int    rr[3];
    int    cc[3];
    int    n;
    wide_t a, b, c, p, s;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != sr) begin rr[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != sc) begin cc[n] = k; n++; end
    p = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      // forward diagonals
      a = mat_copy[rr[0]*4 + cc[k]];
      b = mat_copy[rr[1]*4 + cc[(k+1)%3]];
      c = mat_copy[rr[2]*4 + cc[(k+2)%3]];
      p = p + a * b * c;
      // backward diagonals
      a = mat_copy[rr[0]*4 + cc[k]];
      b = mat_copy[rr[1]*4 + cc[(k+2)%3]];
      c = mat_copy[rr[2]*4 + cc[(k+1)%3]];
      s = s + a * b * c;
    end
    return p - s;
  endfunction

  // store one element; on the 16th, predict all inverse entries
  task automatic load_element(logic signed [ELEM_W-1:0] v);
    wide_t      det, mag, thr_w, cof, q, e;
    logic       sing;
    inv_entry_t r;
    mat_copy[load_cnt] = v;
    load_cnt = (load_cnt + 1) % 16;
    if (load_cnt != 0) return;
    det = 0;
    for (int c = 0; c < 4; c++) begin
      e = mat_copy[c];
      if (c % 2) det = det - e * minor3(0, c);
      else       det = det + e * minor3(0, c);
    end
    mag = (det < 0) ? -det : det;
    thr_w = 0;
    thr_w[THR_W-1:0] = thr_copy;
    thr_w = thr_w <<< (3*FRAC);
    sing = (mag <= thr_w);
    for (int k = 0; k < 16; k++) begin
      r.value     = '0;
      r.index     = k[IDX_W-1:0];
      r.singular  = sing;
      r.saturated = 1'b0;
      r.last      = (k == 15);
      if (!sing) begin
        cof = minor3(k % 4, k / 4);
        if (((k / 4) + (k % 4)) % 2) cof = -cof;
        q = (cof <<< (2*FRAC)) / det;  // truncates toward zero
        if (q > wide_t'(32'sh7FFF_FFFF)) begin
          r.value = 32'sh7FFF_FFFF;
          r.saturated = 1'b1;
        end else if (q < -(wide_t'(1) <<< 31)) begin
          r.value = 32'sh8000_0000;
          r.saturated = 1'b1;
        end else begin
          r.value = q[ELEM_W-1:0];
        end
      end
      expected_inv.push_back(r);
    end
  endtask

  task automatic push_cfg(logic [THR_W-1:0] thr);
    request_t q;
    q.is_cfg = 1'b1;
    q.value  = {1'b0, thr};
    pending_req.push_back(q);
  endtask

  task automatic push_elem(logic [ELEM_W-1:0] v);
    request_t q;
    q.is_cfg = 1'b0;
    q.value  = v;
    pending_req.push_back(q);
  endtask

  function automatic logic [ELEM_W-1:0] small_q();
    return $urandom_range(32'h8_0000, 0) - 32'h4_0000;  // about +-4.0
  endfunction

  task automatic push_matrix(mat_kind_t kind);
    logic [ELEM_W-1:0] m[16];
    int                src;
    for (int k = 0; k < 16; k++) begin
      case (kind)
        MAT_FULL:      m[k] = $urandom;
        MAT_SMALL:     m[k] = small_q();
        MAT_DUP_ROW:   m[k] = small_q();
        MAT_TINY_DIAG: m[k] = (k % 5 == 0) ? $urandom_range(255, 1) : 32'd0;
        default:       m[k] = 32'd0;
      endcase
    end
    // duplicate a row so the determinant is exactly zero
    if (kind == MAT_DUP_ROW) begin
      src = $urandom_range(3, 0);
      for (int c = 0; c < 4; c++) m[((src + 1) % 4)*4 + c] = m[src*4 + c];
    end
    for (int k = 0; k < 16; k++) push_elem(m[k]);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [THR_W-1:0] pick_thr();
    case ($urandom_range(4, 0))
      0:       return '0;
      1:       return '1;
      2:       return THR_RESET;
      3:       return THR_W'($urandom_range(1000, 0));
      default: return THR_W'($urandom);
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start       <= 1'b0;
      cfg_wr_en   <= 1'b0;
      gap_left    = 0;
      settle_cnt  = 0;
    end else begin
      nxt_start = start;
      nxt_wr    = 1'b0;
      if (cfg_wr_en) thr_copy = cfg_wr_data;
      if (start && !busy) begin
        load_element(in_element_value);
        nxt_start = 1'b0;
      end
      if (!nxt_start && !cfg_wr_en) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_req.size() > 0) begin
          if (pending_req[0].is_cfg) begin
            // core must be fully drained before a threshold write
            if (expected_inv.size() == 0 && !busy) settle_cnt++;
            else settle_cnt = 0;
            if (settle_cnt >= SETTLE) begin
              cfg_wr_data <= pending_req[0].value[THR_W-1:0];
              nxt_wr = 1'b1;
              settle_cnt = 0;
              void'(pending_req.pop_front());
            end
          end else begin
            in_element_value <= pending_req[0].value;
            nxt_start = 1'b1;
            gap_left = pick_gap();
            void'(pending_req.pop_front());
          end
        end
      end
      start     <= nxt_start;
      cfg_wr_en <= nxt_wr;
    end
  end

  // result monitor
  always @(posedge clk) begin
    inv_entry_t e;
    if (rst_n && out_valid) begin
      if (expected_inv.size() == 0) begin
        $error("unexpected result, index %0d", out_element_index);
        error_count++;
      end else begin
        e = expected_inv.pop_front();
        if (out_inverse_value !== e.value) begin
          $error("inverse_value exp %h got %h", e.value, out_inverse_value);
          error_count++;
        end
        if (out_element_index !== e.index) begin
          $error("element_index exp %0d got %0d", e.index, out_element_index);
          error_count++;
        end
        if (out_is_singular !== e.singular) begin
          $error("is_singular exp %b got %b", e.singular, out_is_singular);
          error_count++;
        end
        if (out_was_saturated !== e.saturated) begin
          $error("was_saturated exp %b got %b", e.saturated, out_was_saturated);
          error_count++;
        end
        if (out_is_last !== e.last) begin
          $error("is_last exp %b got %b", e.last, out_is_last);
          error_count++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb_matrix_inverse_4x4_core: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_element_value = '0;
    error_count      = 0;
    cycle_count      = 0;
    load_cnt         = 0;
    thr_copy         = THR_RESET;
    for (int k = 0; k < 16; k++) mat_copy[k] = '0;

    // directed: extreme diagonal at reset threshold, then all ones threshold
    for (int k = 0; k < 16; k++) begin
      case (k)
        0:       push_elem(32'h7FFF_FFFF);
        5:       push_elem(32'h8000_0000);
        10:      push_elem(32'h0001_0000);
        15:      push_elem(32'hFFFF_0000);
        default: push_elem(32'd0);
      endcase
    end
    push_cfg('1);
    // tiny determinant with zero threshold: overflowing quotients
    push_cfg('0);
    push_matrix(MAT_TINY_DIAG);

    // random part: every flavor at least once, random thresholds
    for (int m = 0; m < RAND_MATS; m++) begin
      if ($urandom_range(1, 0)) push_cfg(pick_thr());
      if (m < MAT_FLAVORS) push_matrix(mat_kind_t'(m));
      else push_matrix(mat_kind_t'($urandom_range(MAT_FLAVORS - 1, 0)));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so every request and result has settled
    do @(negedge clk);
    while (pending_req.size() != 0 || start || cfg_wr_en || busy ||
           expected_inv.size() != 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_matrix_inverse_4x4_core: done, clean");
    end else begin
      $display("tb_matrix_inverse_4x4_core: done, errors");
    end
    $finish;
  end

endmodule
